/* design/sst_pkg.sv */
// Shared types and constants for the three-stack shared store.
// Used by sst_ram users and the top level; no dependencies.
`default_nettype none

package sst_pkg;

  localparam int SLOT_COUNT  = 256;
  localparam int STACK_COUNT = 3;

  // Slot address bits, and pointer bits that can also hold the empty mark.
  localparam int SLOT_AW = $clog2(SLOT_COUNT);
  localparam int PTR_W   = SLOT_AW + 1;
  localparam int STK_IW  = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;

  localparam int VALUE_W = 32;
  localparam int SEL_W   = 2;

  localparam logic [PTR_W-1:0] PTR_EMPTY = PTR_W'(SLOT_COUNT);
  localparam logic [VALUE_W-1:0] TOP_NONE = '1;

  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_PEEK  = 2'd2;
  localparam logic [1:0] REQ_QUERY = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [SEL_W-1:0]         stack_sel;
    logic signed [VALUE_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [VALUE_W-1:0] top_value;
    logic                     stack_empty;
  } rsp_t;

endpackage

`default_nettype wire

/* design/sst_ram.sv */
// Single-port synchronous RAM with registered read data.
// Generic; no package dependency.
`default_nettype none

module sst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

/* design/three_stacks_shared_store_top.sv */
// Three stacks in one shared store of linked slots: control, top pointers,
// slot value and link memories. Depends on sst_pkg and sst_ram.
//
// Usage: a request (push, pop, peek, query empty) transfers on the req
// channel when req_valid and req_ready are high; its single response
// transfers on the rsp channel when rsp_valid and rsp_ready are high.
// In the accept cycle the slot memory access is issued (write for a push,
// read of the top slot for pop and peek); the busy state then uses the
// registered read data to load the response register and, for a pop, move
// the stack top to the link of the old top slot. No new request is taken
// until the busy state ends. rsp_valid is registered from the finish of the
// busy state, which waits for the response register to be free.
// A new request is taken while the previous response still waits in the
// output register; if the receiver stalls, the second request holds in the
// busy state until the response register frees up, and req_ready stays low.
// Reset empties all stacks and the slot counter at once; slot memory
// contents are not cleared, since an empty stack never reads them.
// Pushes beyond the store size are refused with a full status.
`default_nettype none

module three_stacks_shared_store_top
  import sst_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  typedef enum logic {S_IDLE, S_BUSY} state_t;

  state_t           state;
  logic [PTR_W-1:0] stack_top [STACK_COUNT];
  logic [PTR_W-1:0] next_free;

  // Latched request context for the busy state.
  logic [1:0]        cur_type;
  logic [STK_IW-1:0] cur_idx;
  logic              cur_sel_ok;
  logic              cur_top_empty;
  logic              cur_full;

  logic [VALUE_W-1:0] value_rdata;
  logic [PTR_W-1:0]   below_rdata;

  logic              req_fire;
  logic [STK_IW-1:0] req_idx;
  logic              req_sel_ok;
  logic [PTR_W-1:0]  req_top;
  logic              req_top_empty;
  logic              store_full;
  logic              do_push;
  logic              do_read;
  logic              mem_en;
  logic [SLOT_AW-1:0] mem_addr;
  logic              finish;
  rsp_t              rsp_next;

  assign req_ready     = (state == S_IDLE);
  assign req_fire      = req_valid && req_ready;
  assign req_sel_ok    = (32'(req.stack_sel) < STACK_COUNT);
  assign req_idx       = STK_IW'(req.stack_sel);
  assign req_top       = req_sel_ok ? stack_top[req_idx] : PTR_EMPTY;
  assign req_top_empty = (req_top >= PTR_EMPTY);
  assign store_full    = (next_free >= PTR_EMPTY);

  assign do_push  = req_fire && req_sel_ok && (req.req_type == REQ_PUSH) && !store_full;
  assign do_read  = req_fire && req_sel_ok && !req_top_empty
                 && ((req.req_type == REQ_POP) || (req.req_type == REQ_PEEK));
  assign mem_en   = do_push || do_read;
  assign mem_addr = do_push ? next_free[SLOT_AW-1:0] : req_top[SLOT_AW-1:0];

  sst_ram #(.WIDTH(VALUE_W), .DEPTH(SLOT_COUNT)) u_value_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (do_push),
    .addr  (mem_addr),
    .wdata (req.push_value),
    .rdata (value_rdata)
  );

  sst_ram #(.WIDTH(PTR_W), .DEPTH(SLOT_COUNT)) u_below_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (do_push),
    .addr  (mem_addr),
    .wdata (req_top),
    .rdata (below_rdata)
  );

  assign finish = (state == S_BUSY) && (!rsp_valid || rsp_ready);

  always_comb begin
    rsp_next = '0;
    if (!cur_sel_ok) begin
      rsp_next.status      = ST_EMPTY;
      rsp_next.top_value   = TOP_NONE;
      rsp_next.stack_empty = 1'b1;
    end else begin
      case (cur_type)
        REQ_PUSH: begin
          rsp_next.status      = cur_full ? ST_FULL : ST_OK;
          rsp_next.stack_empty = cur_full && cur_top_empty;
        end
        REQ_POP: begin
          rsp_next.status      = cur_top_empty ? ST_EMPTY : ST_OK;
          rsp_next.stack_empty = cur_top_empty || (below_rdata >= PTR_EMPTY);
        end
        REQ_PEEK: begin
          rsp_next.status      = cur_top_empty ? ST_EMPTY : ST_OK;
          rsp_next.top_value   = cur_top_empty ? TOP_NONE : value_rdata;
          rsp_next.stack_empty = cur_top_empty;
        end
        default: begin
          rsp_next.status      = ST_OK;
          rsp_next.stack_empty = cur_top_empty;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      next_free <= '0;
      for (int i = 0; i < STACK_COUNT; i++) begin
        stack_top[i] <= PTR_EMPTY;
      end
    end else begin
      // Reload on finish, else drop once the waiting response transfers.
      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            state <= S_BUSY;
            if (do_push) begin
              stack_top[req_idx] <= next_free;
              next_free          <= next_free + 1'b1;
            end
          end
        end
        S_BUSY: begin
          // Hold until the response register is free.
          if (finish) begin
            state <= S_IDLE;
            if (cur_sel_ok && (cur_type == REQ_POP) && !cur_top_empty) begin
              stack_top[cur_idx] <= below_rdata;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      cur_type      <= req.req_type;
      cur_idx       <= req_idx;
      cur_sel_ok    <= req_sel_ok;
      cur_top_empty <= req_top_empty;
      cur_full      <= store_full;
    end
    if (finish) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire
